### hdl/smlc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smlc_pkg
// Shared constants, stage indices and pipeline record types for the
// sun and moon key light evaluator.
// ----------------------------------------------------------------------------
package smlc_pkg;

    // Fixed-point units.
    localparam logic [15:0] ONE14 = 16'd16384;
    localparam logic [15:0] ONE15 = 16'd32768;

    // Reciprocals for the divisions by ten and fifteen (scaled by 2^24, rounded down).
    localparam logic [20:0] RECIP10 = 21'd1677721;
    localparam logic [20:0] RECIP15 = 21'd1118481;

    // Taylor coefficients of 2^x in Q1.30.
    localparam logic [32:0] EXP_COEF [8] = '{
        33'd1073741824, 33'd744261118, 33'd257941248, 33'd59597083,
        33'd10327388, 33'd1431680, 33'd165394, 33'd16378
    };

    // Per-channel sun extinction (red, green, blue) and moon tint.
    localparam logic [6:0]  SUN_K [3]     = '{7'd32, 7'd55, 7'd105};
    localparam logic [14:0] MOON_TINT [3] = '{15'd13763, 15'd15729, 15'd22938};
    localparam logic [10:0] MOON_INTEN    = 11'd1147;

    // Pipeline depths of the iterative sections.
    localparam int NDIV_STAGES   = 31;
    localparam int SQRT_STAGES   = 16;
    localparam int EDIV_STAGES   = 23;
    localparam int HORNER_STAGES = 7;

    // Stage indices, counted from the input register as stage zero.
    localparam int ST_NDIV0  = 3;
    localparam int ST_SQRT0  = ST_NDIV0 + NDIV_STAGES;
    localparam int ST_KEY    = ST_SQRT0 + SQRT_STAGES;
    localparam int ST_M1     = ST_KEY + 1;
    localparam int ST_M8     = ST_M1 + 7;
    localparam int ST_EDIV0  = ST_M1 + 1;
    localparam int ST_SETUP  = ST_EDIV0 + EDIV_STAGES;
    localparam int ST_HORN0  = ST_SETUP + 1;
    localparam int ST_PROD   = ST_HORN0 + HORNER_STAGES;
    localparam int ST_SUN    = ST_PROD + 1;
    localparam int ST_OUT    = ST_SUN + 1;
    localparam int LATENCY   = ST_OUT + 1;

    localparam int BASE_DEPTH = ST_SUN + 1;
    localparam int KEY_DEPTH  = ST_SUN - ST_KEY + 1;
    localparam int SKY_DEPTH  = ST_SUN - ST_M8 + 1;

    typedef struct packed {
        logic [2:0][32:0] rem;
        logic [2:0][30:0] quo;
        logic [31:0]      den;
        logic [2:0]       neg;
        logic             zero;
    } ndiv_t;

    typedef struct packed {
        logic [2:0][31:0] rad;
        logic [2:0][19:0] rem;
        logic [2:0][15:0] root;
        logic [2:0]       neg;
        logic             zero;
    } sqrt_t;

    typedef struct packed {
        logic [2:0][23:0] rem;
        logic [2:0][22:0] quo;
        logic [21:0]      den;
        logic [22:0]      nbits;
        logic             hpos;
    } ediv_t;

    typedef struct packed {
        logic [2:0][32:0] acc;
        logic [2:0][16:0] g;
        logic [2:0][6:0]  ip;
    } horn_t;

    typedef struct packed {
        logic [15:0] blend;
        logic        moon;
        logic [15:0] diff;
        logic [15:0] spec;
    } sky_t;

    typedef struct packed {
        logic [2:0][15:0] col;
        logic [15:0]      inten;
    } base_t;

endpackage

### hdl/sun_moon_light_color.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sun_moon_light_color
// Sun and moon key light evaluator: normalized key direction, attenuated
// or tinted colour, intensity, night blend and sky light scales.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge where start is high and busy is low.
//   busy is always low: the block is a fully pipelined datapath that takes
//   one item in every cycle and has no state between items.
//   Each result is shown on the result ports for one cycle, marked by done,
//   once its item has passed through every stage, in the order of the items.
//   The depth is set by the bit-serial stages: a 31-stage divider and a
//   16-stage square root normalize the direction, then a 23-stage divider
//   and a 7-stage polynomial form the sun attenuation per channel.
//   The receiver cannot hold results off, so no stage ever waits.
//   Reset clears the valid bits only; items in flight are dropped and done
//   stays low until a new item has passed through the pipeline.
// ----------------------------------------------------------------------------
module sun_moon_light_color (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] dir_x,
    input  logic signed [15:0] dir_y,
    input  logic signed [15:0] dir_z,
    input  logic        [15:0] base_red,
    input  logic        [15:0] base_green,
    input  logic        [15:0] base_blue,
    input  logic signed [15:0] base_intensity,
    output logic               done,
    output logic signed [15:0] key_x,
    output logic signed [15:0] key_y,
    output logic signed [15:0] key_z,
    output logic        [15:0] out_red,
    output logic        [15:0] out_green,
    output logic        [15:0] out_blue,
    output logic        [14:0] out_intensity,
    output logic               moon_is_key,
    output logic        [15:0] night_blend,
    output logic        [15:0] sky_diffuse_scale,
    output logic        [15:0] sky_specular_scale
);
    import smlc_pkg::*;

    logic [LATENCY-1:0] vld_reg;

    base_t              base_dly [BASE_DEPTH];
    logic signed [15:0] key_dly  [KEY_DEPTH][3];
    sky_t               sky_dly  [SKY_DEPTH];
    sky_t               sky_next;

    logic [15:0] mag0_reg [3];
    logic [2:0]  neg0_reg;
    logic [30:0] sq1_reg  [3];
    logic [2:0]  neg1_reg;
    ndiv_t       ndiv_in_reg;
    ndiv_t       ndiv_reg [NDIV_STAGES];
    sqrt_t       sqrt_in;
    sqrt_t       sqrt_reg [SQRT_STAGES];
    logic signed [15:0] key_next [3];

    // Night and moon-height smoothstep path.
    logic [20:0] nt_x_reg, mt_x_reg;
    logic        nt_pos_reg, mt_pos_reg;
    logic [21:0] d_reg;
    logic        hpos_reg;
    logic [17:0] nq0_reg, mq0_reg;
    logic [20:0] nt_x2_reg, mt_x2_reg;
    logic        nt_pos2_reg, mt_pos2_reg;
    logic [15:0] nt_t_reg, mt_t_reg;
    logic [30:0] nt_tt_reg, mt_tt_reg;
    logic [16:0] nt_w_reg, mt_w_reg;
    logic [47:0] nt_p_reg, mt_p_reg;
    logic [15:0] blend6_reg, me6_reg;
    logic        moon6_reg;
    logic [15:0] blend7_reg;
    logic        moon7_reg;
    logic [11:0] nd7_reg, ns7_reg;

    // Sun attenuation path.
    ediv_t       ediv_in;
    ediv_t       ediv_reg [EDIV_STAGES];
    horn_t       horn_in_reg;
    horn_t       horn_reg [HORNER_STAGES];
    logic [48:0] prod_reg [3];
    logic [6:0]  prod_ip_reg [3];
    logic [15:0] sun_col_reg [3];

    logic signed [15:0] key_out_reg [3];
    logic [15:0] col_out_reg [3];
    logic [14:0] inten_out_reg;
    logic        moon_out_reg;
    logic [15:0] blend_out_reg, diff_out_reg, spec_out_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], start && !busy};
        end
    end

    // ------------------------------------------------------------------
    // Input stage, squares and squared length.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        logic [15:0] raw [3];
        logic [31:0] sq;
        logic [31:0] len2;
        raw[0] = dir_x;
        raw[1] = dir_y;
        raw[2] = dir_z;
        for (int i = 0; i < 3; i++)
        begin
            mag0_reg[i] <= raw[i][15] ? (~raw[i] + 16'd1) : raw[i];
            neg0_reg[i] <= raw[i][15];
            sq = 32'(mag0_reg[i]) * 32'(mag0_reg[i]);
            sq1_reg[i] <= sq[30:0];
        end
        neg1_reg <= neg0_reg;
        len2 = 32'(sq1_reg[0]) + 32'(sq1_reg[1]) + 32'(sq1_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            ndiv_in_reg.rem[i] <= 33'(sq1_reg[i]);
            ndiv_in_reg.quo[i] <= '0;
        end
        ndiv_in_reg.den  <= len2;
        ndiv_in_reg.neg  <= neg1_reg;
        ndiv_in_reg.zero <= (len2 == 32'd0);
    end

    // ------------------------------------------------------------------
    // Restoring divider: q = floor(a^2 * 2^30 / len2), one bit per stage.
    // ------------------------------------------------------------------
    for (genvar j = 0; j < NDIV_STAGES; j++)
    begin : g_ndiv
        ndiv_t cur;
        ndiv_t nxt;
        if (j == 0)
        begin : g_src
            assign cur = ndiv_in_reg;
        end
        else
        begin : g_src
            assign cur = ndiv_reg[j-1];
        end

        always_comb
        begin
            logic [32:0] dif;
            nxt = cur;
            for (int i = 0; i < 3; i++)
            begin
                dif = cur.rem[i] - {1'b0, cur.den};
                if (cur.rem[i] >= {1'b0, cur.den})
                begin
                    nxt.rem[i] = {dif[31:0], 1'b0};
                    nxt.quo[i] = {cur.quo[i][29:0], 1'b1};
                end
                else
                begin
                    nxt.rem[i] = {cur.rem[i][31:0], 1'b0};
                    nxt.quo[i] = {cur.quo[i][29:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            ndiv_reg[j] <= nxt;
        end
    end

    // ------------------------------------------------------------------
    // Integer square root of the quotient, two radicand bits per stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sqrt_in.rad[i]  = {1'b0, ndiv_reg[NDIV_STAGES-1].quo[i]};
            sqrt_in.rem[i]  = '0;
            sqrt_in.root[i] = '0;
        end
        sqrt_in.neg  = ndiv_reg[NDIV_STAGES-1].neg;
        sqrt_in.zero = ndiv_reg[NDIV_STAGES-1].zero;
    end

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        sqrt_t cur;
        sqrt_t nxt;
        if (k == 0)
        begin : g_src
            assign cur = sqrt_in;
        end
        else
        begin : g_src
            assign cur = sqrt_reg[k-1];
        end

        always_comb
        begin
            logic [19:0] rw;
            logic [19:0] test;
            nxt = cur;
            for (int i = 0; i < 3; i++)
            begin
                rw   = {cur.rem[i][17:0], cur.rad[i][31:30]};
                test = {2'b00, cur.root[i], 2'b01};
                nxt.rad[i] = {cur.rad[i][29:0], 2'b00};
                if (rw >= test)
                begin
                    nxt.rem[i]  = rw - test;
                    nxt.root[i] = {cur.root[i][14:0], 1'b1};
                end
                else
                begin
                    nxt.rem[i]  = rw;
                    nxt.root[i] = {cur.root[i][14:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            sqrt_reg[k] <= nxt;
        end
    end

    // The largest lo with (2lo-1)^2 <= q is (isqrt(q)+1)/2.
    always_comb
    begin
        logic [16:0] lo;
        for (int i = 0; i < 3; i++)
        begin
            lo = (17'(sqrt_reg[SQRT_STAGES-1].root[i]) + 17'd1) >> 1;
            if (sqrt_reg[SQRT_STAGES-1].zero)
            begin
                key_next[i] = (i == 1) ? ONE14 : 16'd0;
            end
            else if (sqrt_reg[SQRT_STAGES-1].neg[i])
            begin
                key_next[i] = -lo[15:0];
            end
            else
            begin
                key_next[i] = lo[15:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Delay lines for the items that skip the arithmetic sections.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        base_dly[0].col[0] <= base_red;
        base_dly[0].col[1] <= base_green;
        base_dly[0].col[2] <= base_blue;
        base_dly[0].inten  <= base_intensity;
        for (int n = 1; n < BASE_DEPTH; n++)
        begin
            base_dly[n] <= base_dly[n-1];
        end
        for (int i = 0; i < 3; i++)
        begin
            key_dly[0][i] <= key_next[i];
            for (int n = 1; n < KEY_DEPTH; n++)
            begin
                key_dly[n][i] <= key_dly[n-1][i];
            end
        end
        sky_dly[0] <= sky_next;
        for (int n = 1; n < SKY_DEPTH; n++)
        begin
            sky_dly[n] <= sky_dly[n-1];
        end
    end

    // ------------------------------------------------------------------
    // Night blend and sky scales from the sun height.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        logic signed [23:0] h24;
        logic signed [23:0] night;
        logic signed [23:0] mnum;
        logic signed [23:0] dd;
        logic [41:0] nprod, mprod;
        logic [21:0] rn, rm;
        logic [17:0] tn, tm;
        logic [31:0] sqn, sqm;
        logic [47:0] rs;
        logic [15:0] sn, sm;
        logic [26:0] pd, ps;

        // Stage m1: numerators of the two ramps and the sun divisor.
        h24   = 24'(key_dly[0][1]);
        night = 24'sd100 * h24 + 24'sd131072;
        mnum  = 24'sd98304 - 24'sd100 * h24;
        dd    = 24'sd200 * h24 + 24'sd16384;
        nt_pos_reg <= (night > 24'sd0);
        mt_pos_reg <= (mnum > 24'sd0);
        nt_x_reg   <= 21'(night + 24'sd5);
        mt_x_reg   <= 21'(mnum + 24'sd7);
        d_reg      <= dd[21:0];
        hpos_reg   <= (h24 > 24'sd0);

        // Stage m2: quotient estimate, at most one short.
        nprod = 42'(nt_x_reg) * 42'(RECIP10);
        mprod = 42'(mt_x_reg) * 42'(RECIP15);
        nq0_reg     <= nprod[41:24];
        mq0_reg     <= mprod[41:24];
        nt_x2_reg   <= nt_x_reg;
        mt_x2_reg   <= mt_x_reg;
        nt_pos2_reg <= nt_pos_reg;
        mt_pos2_reg <= mt_pos_reg;

        // Stage m3: correct the estimate and clamp the ramp to 0..1.
        rn = 22'(nt_x2_reg) - 22'(nq0_reg) * 22'd10;
        rm = 22'(mt_x2_reg) - 22'(mq0_reg) * 22'd15;
        tn = (rn >= 22'd10) ? nq0_reg + 18'd1 : nq0_reg;
        tm = (rm >= 22'd15) ? mq0_reg + 18'd1 : mq0_reg;
        if (!nt_pos2_reg)
        begin
            nt_t_reg <= '0;
        end
        else if (tn > 18'(ONE15))
        begin
            nt_t_reg <= ONE15;
        end
        else
        begin
            nt_t_reg <= tn[15:0];
        end
        if (!mt_pos2_reg)
        begin
            mt_t_reg <= '0;
        end
        else if (tm > 18'(ONE15))
        begin
            mt_t_reg <= ONE15;
        end
        else
        begin
            mt_t_reg <= tm[15:0];
        end

        // Stage m4: t^2 and (3 - 2t).
        sqn = 32'(nt_t_reg) * 32'(nt_t_reg);
        sqm = 32'(mt_t_reg) * 32'(mt_t_reg);
        nt_tt_reg <= sqn[30:0];
        mt_tt_reg <= sqm[30:0];
        nt_w_reg  <= 17'd98304 - {nt_t_reg, 1'b0};
        mt_w_reg  <= 17'd98304 - {mt_t_reg, 1'b0};

        // Stage m5: cubic.
        nt_p_reg <= 48'(nt_tt_reg) * 48'(nt_w_reg);
        mt_p_reg <= 48'(mt_tt_reg) * 48'(mt_w_reg);

        // Stage m6: round to Q1.15; a blend just at one half keeps the sun.
        rs = nt_p_reg + 48'd536870912;
        sn = rs[45:30];
        rs = mt_p_reg + 48'd536870912;
        sm = rs[45:30];
        blend6_reg <= ONE15 - sn;
        moon6_reg  <= ((ONE15 - sn) > ONE14);
        me6_reg    <= sm;

        // Stage m7: sky night levels.
        pd = 27'(me6_reg) * 27'd1540 + 27'd16384;
        ps = 27'(me6_reg) * 27'd1966 + 27'd16384;
        nd7_reg    <= 12'd590 + 12'(pd[26:15]);
        ns7_reg    <= 12'd819 + 12'(ps[26:15]);
        blend7_reg <= blend6_reg;
        moon7_reg  <= moon6_reg;
    end

    // Stage m8: lerp from one to the night level by the blend.
    always_comb
    begin
        logic [32:0] qd, qs;
        qd = 33'(ONE15 - 16'(nd7_reg)) * 33'(blend7_reg) + 33'd16384;
        qs = 33'(ONE15 - 16'(ns7_reg)) * 33'(blend7_reg) + 33'd16384;
        sky_next.blend = blend7_reg;
        sky_next.moon  = moon7_reg;
        sky_next.diff  = ONE15 - qd[30:15];
        sky_next.spec  = ONE15 - qs[30:15];
    end

    // ------------------------------------------------------------------
    // Sun exponent: round(K * 2^30 / d), one quotient bit per stage.
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ediv_in.rem[i] = 24'({SUN_K[i], 7'd0});
            ediv_in.quo[i] = '0;
        end
        ediv_in.den   = d_reg;
        ediv_in.nbits = {2'b00, d_reg[21:1]};
        ediv_in.hpos  = hpos_reg;
    end

    for (genvar j = 0; j < EDIV_STAGES; j++)
    begin : g_ediv
        ediv_t cur;
        ediv_t nxt;
        if (j == 0)
        begin : g_src
            assign cur = ediv_in;
        end
        else
        begin : g_src
            assign cur = ediv_reg[j-1];
        end

        always_comb
        begin
            logic [23:0] rs;
            nxt = cur;
            nxt.nbits = {cur.nbits[21:0], 1'b0};
            for (int i = 0; i < 3; i++)
            begin
                rs = {cur.rem[i][22:0], cur.nbits[22]};
                if (rs >= {2'b00, cur.den})
                begin
                    nxt.rem[i] = rs - {2'b00, cur.den};
                    nxt.quo[i] = {cur.quo[i][21:0], 1'b1};
                end
                else
                begin
                    nxt.rem[i] = rs;
                    nxt.quo[i] = {cur.quo[i][21:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            ediv_reg[j] <= nxt;
        end
    end

    // Split the exponent into integer shift and fraction.
    always_ff @(posedge clk)
    begin
        logic [22:0] e16;
        for (int i = 0; i < 3; i++)
        begin
            e16 = ediv_reg[EDIV_STAGES-1].hpos ? ediv_reg[EDIV_STAGES-1].quo[i]
                                               : {SUN_K[i], 16'd0};
            horn_in_reg.ip[i]  <= e16[22:16];
            horn_in_reg.g[i]   <= 17'h10000 - 17'(e16[15:0]);
            horn_in_reg.acc[i] <= EXP_COEF[7];
        end
    end

    // Horner steps of the series for 2^(g/65536), one coefficient per stage.
    for (genvar k = 0; k < HORNER_STAGES; k++)
    begin : g_horn
        horn_t cur;
        horn_t nxt;
        if (k == 0)
        begin : g_src
            assign cur = horn_in_reg;
        end
        else
        begin : g_src
            assign cur = horn_reg[k-1];
        end

        always_comb
        begin
            logic [49:0] pg;
            nxt = cur;
            for (int i = 0; i < 3; i++)
            begin
                pg = 50'(cur.acc[i]) * 50'(cur.g[i]) + 50'd32768;
                nxt.acc[i] = EXP_COEF[HORNER_STAGES-1-k] + pg[48:16];
            end
        end

        always_ff @(posedge clk)
        begin
            horn_reg[k] <= nxt;
        end
    end

    always_ff @(posedge clk)
    begin
        logic [7:0]  sh;
        logic [50:0] sum;
        logic [50:0] r;
        for (int i = 0; i < 3; i++)
        begin
            prod_reg[i]    <= 49'(base_dly[ST_PROD-1].col[i]) *
                              49'(horn_reg[HORNER_STAGES-1].acc[i]);
            prod_ip_reg[i] <= horn_reg[HORNER_STAGES-1].ip[i];

            // Rounded right shift by 31 + n; shifts past 47 give zero.
            sh  = 8'(prod_ip_reg[i]) + 8'd31;
            sum = 51'(prod_reg[i]) + (51'd1 << (sh - 8'd1));
            r   = sum >> sh;
            if (prod_ip_reg[i] > 7'd16)
            begin
                sun_col_reg[i] <= '0;
            end
            else if (r > 51'd65535)
            begin
                sun_col_reg[i] <= 16'hFFFF;
            end
            else
            begin
                sun_col_reg[i] <= r[15:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: pick sun or moon as the key light.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        base_t       b;
        sky_t        sk;
        logic [31:0] mc;
        logic [31:0] mi;
        b  = base_dly[BASE_DEPTH-1];
        sk = sky_dly[SKY_DEPTH-1];
        mi = 32'(b.inten[14:0]) * 32'(MOON_INTEN) + 32'd16384;
        for (int i = 0; i < 3; i++)
        begin
            mc = 32'(b.col[i]) * 32'(MOON_TINT[i]) + 32'd16384;
            if (sk.moon)
            begin
                col_out_reg[i] <= mc[30:15];
                key_out_reg[i] <= -key_dly[KEY_DEPTH-1][i];
            end
            else
            begin
                col_out_reg[i] <= sun_col_reg[i];
                key_out_reg[i] <= key_dly[KEY_DEPTH-1][i];
            end
        end
        if (b.inten[15])
        begin
            inten_out_reg <= '0;
        end
        else if (sk.moon)
        begin
            inten_out_reg <= mi[29:15];
        end
        else
        begin
            inten_out_reg <= b.inten[14:0];
        end
        moon_out_reg  <= sk.moon;
        blend_out_reg <= sk.blend;
        diff_out_reg  <= sk.diff;
        spec_out_reg  <= sk.spec;
    end

    assign done               = vld_reg[ST_OUT];
    assign key_x              = key_out_reg[0];
    assign key_y              = key_out_reg[1];
    assign key_z              = key_out_reg[2];
    assign out_red            = col_out_reg[0];
    assign out_green          = col_out_reg[1];
    assign out_blue           = col_out_reg[2];
    assign out_intensity      = inten_out_reg;
    assign moon_is_key        = moon_out_reg;
    assign night_blend        = blend_out_reg;
    assign sky_diffuse_scale  = diff_out_reg;
    assign sky_specular_scale = spec_out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item did not come out after the pipeline latency");

    a_moon_sel: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (moon_is_key == (night_blend > ONE14)))
        else $error("moon selection disagrees with the night blend");

    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (night_blend <= ONE15 && sky_diffuse_scale <= ONE15 &&
                  sky_specular_scale <= ONE15))
        else $error("blend or sky scale above one");

    a_key_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (key_x != 16'sd0 || key_y != 16'sd0 || key_z != 16'sd0))
        else $error("key direction is zero");

endmodule
